// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the three-plane intersection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TPIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion of the form "antecedent, then next cycle consequent".
`define TPIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `TPIC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/tpic_pkg.sv =====
// Package with types and constants of the three-plane intersection block.
`timescale 1ns / 1ps
package tpic_pkg;

  localparam int NRM_W    = 16;
  localparam int OFS_W    = 32;
  localparam int COORD_W  = 32;
  localparam int DTOL_W   = 47;
  localparam int PTOL_W   = 30;
  localparam int CFG_W    = 47;
  localparam int PTOL_SH  = 28;
  localparam int DEN_W    = 49;
  localparam int MAG_W    = 64;
  localparam int REM_W    = DEN_W + 1;
  localparam int Q_W      = 32;
  localparam int SCALE_SH = 14;
  localparam int OVF_SH   = Q_W - SCALE_SH;
  localparam int DIV_STAGES = Q_W;

  // Depth must be a power of two: the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  localparam logic [DTOL_W-1:0] DET_TOL_RST = 47'd4398047;
  localparam logic [PTOL_W-1:0] PAR_TOL_RST = '0;

  typedef enum logic [1:0] {
    OUT_FOUND    = 2'd0,
    OUT_PARALLEL = 2'd1,
    OUT_SINGULAR = 2'd2
  } outcome_e;

  typedef enum logic {
    CFG_DET_TOL = 1'b0,
    CFG_PAR_TOL = 1'b1
  } cfg_idx_e;

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    outcome_e                  outcome;
    logic [2:0]                neg;
    logic [2:0][MAG_W-1:0]     mag;
    logic [DEN_W-1:0]          den;
  } job_t;

  // State of the three dividers at one stage of the back pipeline.
  typedef struct packed {
    outcome_e                  outcome;
    logic [2:0]                neg;
    logic [2:0]                ovf;
    logic [DEN_W-1:0]          den;
    logic [2:0][REM_W-1:0]     rem;
    logic [2:0][Q_W-1:0]       rest;
    logic [2:0][Q_W-1:0]       quo;
  } div_t;

endpackage

// ===== hw/rtl/tpic_front.sv =====
// Front part: product pipeline, parallel and determinant tests, numerators.
`timescale 1ns / 1ps
module tpic_front import tpic_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    in_valid_i,
  input  logic signed [NRM_W-1:0] nrm_i [3][3],
  input  logic signed [OFS_W-1:0] ofs_i [3],
  input  logic [DTOL_W-1:0]       det_tol_i,
  input  logic [PTOL_W-1:0]       par_tol_i,
  output logic                    job_valid_o,
  output job_t                    job_o
);

  logic [4:0] v_q;

  // Stage 1 registers.
  logic signed [31:0] xa_q [3][3];
  logic signed [31:0] xb_q [3][3];
  logic signed [47:0] od_q [6];
  logic signed [NRM_W-1:0] n1_q [3];
  logic signed [OFS_W-1:0] d1_q;

  // Stage 2 registers.
  logic [31:0]             cabs_q [3][3];
  logic signed [32:0]      m_q [3];
  logic signed [48:0]      e_q [3];
  logic signed [NRM_W-1:0] n2_q [3];
  logic signed [OFS_W-1:0] d2_q;

  // Stage 3 registers.
  logic [63:0]        sq_q [3][3];
  logic signed [48:0] dt_q [3];
  logic signed [64:0] nt_q [9];

  // Stage 4 registers.
  logic [65:0]        ss_q [3];
  logic signed [50:0] det_q;
  logic signed [67:0] num_q [3];

  // Stage 5 register.
  job_t job_d, job_q;

  // Valid bits move with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  // Stage 1: cross-product terms of each normal pair and offset products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          xa_q[p][c] <= nrm_i[(p == 2) ? 1 : 0][(c == 2) ? 0 : c + 1] *
                        nrm_i[(p == 0) ? 1 : 2][(c == 0) ? 2 : c - 1];
          xb_q[p][c] <= nrm_i[(p == 2) ? 1 : 0][(c == 0) ? 2 : c - 1] *
                        nrm_i[(p == 0) ? 1 : 2][(c == 2) ? 0 : c + 1];
        end
      end
      od_q[0] <= ofs_i[1] * nrm_i[2][2];
      od_q[1] <= ofs_i[2] * nrm_i[1][2];
      od_q[2] <= ofs_i[1] * nrm_i[2][1];
      od_q[3] <= ofs_i[2] * nrm_i[1][1];
      od_q[4] <= nrm_i[1][0] * ofs_i[2];
      od_q[5] <= nrm_i[2][0] * ofs_i[1];
      n1_q    <= nrm_i[0];
      d1_q    <= ofs_i[0];
    end
  end

  // Stage 2: cross components, their magnitudes, minors and offset minors.
  always_ff @(posedge clk_i) begin
    logic signed [32:0] cd [3][3];
    if (en_i) begin
      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          cd[p][c] = xa_q[p][c] - xb_q[p][c];
          cabs_q[p][c] <= cd[p][c][32] ? 32'(-cd[p][c]) : 32'(cd[p][c]);
        end
      end
      m_q[0] <= cd[2][0];
      m_q[1] <= -cd[2][1];
      m_q[2] <= cd[2][2];
      e_q[0] <= od_q[0] - od_q[1];
      e_q[1] <= od_q[2] - od_q[3];
      e_q[2] <= od_q[4] - od_q[5];
      n2_q   <= n1_q;
      d2_q   <= d1_q;
    end
  end

  // Stage 3: squares, determinant terms and numerator terms.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          sq_q[p][c] <= cabs_q[p][c] * cabs_q[p][c];
        end
      end
      dt_q[0] <= n2_q[0] * m_q[0];
      dt_q[1] <= n2_q[1] * m_q[1];
      dt_q[2] <= n2_q[2] * m_q[2];
      nt_q[0] <= d2_q * m_q[0];
      nt_q[1] <= n2_q[1] * e_q[0];
      nt_q[2] <= n2_q[2] * e_q[1];
      nt_q[3] <= n2_q[0] * e_q[0];
      nt_q[4] <= d2_q * m_q[1];
      nt_q[5] <= n2_q[2] * e_q[2];
      nt_q[6] <= n2_q[0] * e_q[1];
      nt_q[7] <= n2_q[1] * e_q[2];
      nt_q[8] <= d2_q * m_q[2];
    end
  end

  // Stage 4: sums of squares, determinant and the three numerators.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < 3; p++) begin
        ss_q[p] <= 66'(sq_q[p][0]) + 66'(sq_q[p][1]) + 66'(sq_q[p][2]);
      end
      det_q    <= dt_q[0] - dt_q[1] + dt_q[2];
      num_q[0] <= -nt_q[0] + nt_q[1] - nt_q[2];
      num_q[1] <= -nt_q[3] + nt_q[4] - nt_q[5];
      num_q[2] <= nt_q[6] + nt_q[7] - nt_q[8];
    end
  end

  // Stage 5: classify and split into sign and magnitude.
  always_comb begin
    logic [57:0]        lim;
    logic [50:0]        adet;
    logic signed [67:0] anum;
    logic               parallel;
    logic               singular;
    lim      = {par_tol_i, {PTOL_SH{1'b0}}};
    parallel = (ss_q[0] < 66'(lim)) || (ss_q[1] < 66'(lim)) || (ss_q[2] < 66'(lim));
    adet     = det_q[50] ? 51'(-det_q) : 51'(det_q);
    singular = (det_q == '0) || (adet < 51'(det_tol_i));
    job_d.den = adet[DEN_W-1:0];
    for (int k = 0; k < 3; k++) begin
      anum         = num_q[k][67] ? -num_q[k] : num_q[k];
      job_d.mag[k] = anum[MAG_W-1:0];
      job_d.neg[k] = num_q[k][67] ^ det_q[50];
    end
    if (parallel) begin
      job_d.outcome = OUT_PARALLEL;
    end else if (singular) begin
      job_d.outcome = OUT_SINGULAR;
    end else begin
      job_d.outcome = OUT_FOUND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = v_q[4];
  assign job_o       = job_q;

endmodule

// ===== hw/rtl/tpic_queue.sv =====
// Short queue of classified words between the front and back parts.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tpic_queue import tpic_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

  `TPIC_ASSERT(a_no_overflow, push_i |-> !full_o, "queue written while full")
  `TPIC_ASSERT(a_no_underflow, pop_i |-> !empty_o, "queue read while empty")
  `TPIC_ASSERT_NEXT(a_count_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "bad count")

endmodule

// ===== hw/rtl/tpic_div_stage.sv =====
// One restoring division step for the three coordinates.
`timescale 1ns / 1ps
module tpic_div_stage import tpic_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t stage_i,
  output logic valid_o,
  output div_t stage_o
);

  div_t stage_d, stage_q;
  logic valid_q;

  // Shift in one dividend bit, subtract when the remainder allows.
  always_comb begin
    logic [REM_W-1:0] r2;
    logic             ge;
    stage_d = stage_i;
    for (int k = 0; k < 3; k++) begin
      r2 = {stage_i.rem[k][REM_W-2:0], stage_i.rest[k][Q_W-1]};
      ge = (r2 >= {1'b0, stage_i.den});
      stage_d.rem[k]  = ge ? r2 - {1'b0, stage_i.den} : r2;
      stage_d.quo[k]  = {stage_i.quo[k][Q_W-2:0], ge};
      stage_d.rest[k] = {stage_i.rest[k][Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== hw/rtl/tpic_back.sv =====
// Back part: overflow check, pipelined dividers, saturation, output register.
`timescale 1ns / 1ps
module tpic_back import tpic_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  job_t                      job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic signed [COORD_W-1:0] point_z_o,
  output logic [1:0]                outcome_o,
  output logic                      saturated_o
);

  logic en;
  logic sv [DIV_STAGES+1];
  div_t st [DIV_STAGES+1];
  div_t b0_d;

  logic                  out_valid_q;
  logic [2:0][COORD_W-1:0] pt_d, pt_q;
  outcome_e              oc_q;
  logic                  sat_d, sat_q;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && job_valid_i;

  // Entry stage: a quotient of 2^32 or more is flagged, the rest is divided.
  always_comb begin
    b0_d.outcome = job_i.outcome;
    b0_d.neg     = job_i.neg;
    b0_d.den     = job_i.den;
    for (int k = 0; k < 3; k++) begin
      b0_d.ovf[k]  = (67'(job_i.mag[k]) >= {job_i.den, {OVF_SH{1'b0}}});
      b0_d.rem[k]  = REM_W'(job_i.mag[k][MAG_W-1:OVF_SH]);
      b0_d.rest[k] = {job_i.mag[k][OVF_SH-1:0], {SCALE_SH{1'b0}}};
      b0_d.quo[k]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st[0] <= b0_d;
    end
  end

  // One quotient bit per stage.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tpic_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[g]),
      .stage_i (st[g]),
      .valid_o (sv[g+1]),
      .stage_o (st[g+1])
    );
  end

  // Apply sign and clamp to the Q16.16 range.
  always_comb begin
    logic [Q_W-1:0] q;
    logic           s;
    sat_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      q = st[DIV_STAGES].quo[k];
      if (st[DIV_STAGES].neg[k]) begin
        s        = st[DIV_STAGES].ovf[k] || (q > COORD_MIN);
        pt_d[k]  = s ? COORD_MIN : (COORD_W'(0) - q);
      end else begin
        s        = st[DIV_STAGES].ovf[k] || (q > COORD_MAX);
        pt_d[k]  = s ? COORD_MAX : q;
      end
      sat_d = sat_d | s;
    end
    if (st[DIV_STAGES].outcome != OUT_FOUND) begin
      pt_d  = '0;
      sat_d = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q  <= pt_d;
      oc_q  <= st[DIV_STAGES].outcome;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = pt_q[0];
  assign point_y_o   = pt_q[1];
  assign point_z_o   = pt_q[2];
  assign outcome_o   = oc_q;
  assign saturated_o = sat_q;

endmodule

// ===== hw/rtl/three_plane_intersect_cramer.sv =====
// Path of a word: front stages, queue, entry stage, divider stages, output register.
// Throughput: one word per cycle when neither side stalls; the front product pipeline
// and the 32-stage divider pipeline each take a new word every cycle they are enabled.
// A four-word queue between front and back absorbs output stalls.
// Reset: asynchronous, active low; clears all valid bits and the queue, and
// loads the reset values of both tolerances.
`timescale 1ns / 1ps
module three_plane_intersect_cramer import tpic_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [NRM_W-1:0]   first_normal_x_i,
  input  logic signed [NRM_W-1:0]   first_normal_y_i,
  input  logic signed [NRM_W-1:0]   first_normal_z_i,
  input  logic signed [OFS_W-1:0]   first_offset_i,
  input  logic signed [NRM_W-1:0]   second_normal_x_i,
  input  logic signed [NRM_W-1:0]   second_normal_y_i,
  input  logic signed [NRM_W-1:0]   second_normal_z_i,
  input  logic signed [OFS_W-1:0]   second_offset_i,
  input  logic signed [NRM_W-1:0]   third_normal_x_i,
  input  logic signed [NRM_W-1:0]   third_normal_y_i,
  input  logic signed [NRM_W-1:0]   third_normal_z_i,
  input  logic signed [OFS_W-1:0]   third_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic signed [COORD_W-1:0] point_z_o,
  output logic [1:0]                outcome_o,
  output logic                      saturated_o
);

  logic [DTOL_W-1:0] det_tol_q;
  logic [PTOL_W-1:0] par_tol_q;

  logic signed [NRM_W-1:0] nrm [3][3];
  logic signed [OFS_W-1:0] ofs [3];

  logic job_valid, q_full, q_empty, pop;
  job_t job_front, job_back;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_tol_q <= DET_TOL_RST;
      par_tol_q <= PAR_TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DET_TOL: det_tol_q <= cfg_data_i[DTOL_W-1:0];
        CFG_PAR_TOL: par_tol_q <= cfg_data_i[PTOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign nrm[0][0] = first_normal_x_i;
  assign nrm[0][1] = first_normal_y_i;
  assign nrm[0][2] = first_normal_z_i;
  assign nrm[1][0] = second_normal_x_i;
  assign nrm[1][1] = second_normal_y_i;
  assign nrm[1][2] = second_normal_z_i;
  assign nrm[2][0] = third_normal_x_i;
  assign nrm[2][1] = third_normal_y_i;
  assign nrm[2][2] = third_normal_z_i;
  assign ofs[0]    = first_offset_i;
  assign ofs[1]    = second_offset_i;
  assign ofs[2]    = third_offset_i;

  // The front pipeline advances whenever the queue has room.
  assign in_ready_o = !q_full;

  tpic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (!q_full),
    .in_valid_i  (in_valid_i),
    .nrm_i       (nrm),
    .ofs_i       (ofs),
    .det_tol_i   (det_tol_q),
    .par_tol_i   (par_tol_q),
    .job_valid_o (job_valid),
    .job_o       (job_front)
  );

  tpic_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid && !q_full),
    .data_i  (job_front),
    .pop_i   (pop),
    .data_o  (job_back),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tpic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (job_back),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .outcome_o   (outcome_o),
    .saturated_o (saturated_o)
  );

endmodule

// ===== test/tb_three_plane_intersect_cramer.sv =====
// Self-checking testbench for the three-plane intersection block.
`timescale 1ns / 1ps
module tb_three_plane_intersect_cramer;
  import tpic_pkg::*;

  typedef logic signed [127:0] wide_t;

  // One input word: three planes, normals in Q2.14 and offsets in Q16.16.
  typedef struct {
    logic signed [NRM_W-1:0] nrm[3][3];
    logic signed [OFS_W-1:0] ofs[3];
  } planes_t;

  // One result word.
  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    outcome_e                  outcome;
    logic                      sat;
  } point_t;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 45;

  // Scoreboard: predicts each intersection and checks results in order.
  class intersect_scoreboard;
    logic [DTOL_W-1:0] det_tol;
    logic [PTOL_W-1:0] par_tol;
    point_t            pending_q[$];
    int                errors;
    int                checked;
    int                outcome_cnt[3];
    int                sat_cnt;

    function new();
      det_tol = DET_TOL_RST;
      par_tol = PAR_TOL_RST;
    endfunction

    // Squared magnitude of the cross product of two normals.
    function longint unsigned cross_sq(longint n0, longint n1, longint n2,
                                       longint m0, longint m1, longint m2);
      longint cx, cy, cz;
      longint unsigned ux, uy, uz;
      cx = n1 * m2 - n2 * m1;
      cy = n2 * m0 - n0 * m2;
      cz = n0 * m1 - n1 * m0;
      ux = cx < 0 ? -cx : cx;
      uy = cy < 0 ? -cy : cy;
      uz = cz < 0 ? -cz : cz;
      return ux * ux + uy * uy + uz * uz;
    endfunction

    // Divide a numerator by the determinant into Q16.16, with clamping.
    function logic [COORD_W-1:0] divide_coord(wide_t num, longint det, inout logic sat);
      logic   neg;
      logic [127:0] mag, den, quo;
      neg = num < 0;
      mag = neg ? -num : num;
      if (det < 0) begin
        neg = !neg;
        den = 128'(-det);
      end else begin
        den = 128'(det);
      end
      quo = (mag << SCALE_SH) / den;
      if (neg) begin
        if (quo > 128'h8000_0000) begin
          sat = 1'b1;
          return COORD_MIN;
        end
        return -quo[COORD_W-1:0];
      end
      if (quo > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        return COORD_MAX;
      end
      return quo[COORD_W-1:0];
    endfunction

    function point_t predict_point(planes_t p);
      point_t r;
      longint a1, b1, c1, d1, a2, b2, c2, d2, a3, b3, c3, d3;
      longint m1, m2, m3, det;
      longint unsigned lim, adet;
      wide_t nx, ny, nz;
      logic sat;
      r = '{px: '0, py: '0, pz: '0, outcome: OUT_FOUND, sat: 1'b0};
      a1 = p.nrm[0][0]; b1 = p.nrm[0][1]; c1 = p.nrm[0][2]; d1 = p.ofs[0];
      a2 = p.nrm[1][0]; b2 = p.nrm[1][1]; c2 = p.nrm[1][2]; d2 = p.ofs[1];
      a3 = p.nrm[2][0]; b3 = p.nrm[2][1]; c3 = p.nrm[2][2]; d3 = p.ofs[2];
      lim = longint'(par_tol) << PTOL_SH;
      if (cross_sq(a1, b1, c1, a2, b2, c2) < lim || cross_sq(a1, b1, c1, a3, b3, c3) < lim ||
          cross_sq(a2, b2, c2, a3, b3, c3) < lim) begin
        r.outcome = OUT_PARALLEL;
        return r;
      end
      m1 = b2 * c3 - b3 * c2;
      m2 = a2 * c3 - a3 * c2;
      m3 = a2 * b3 - a3 * b2;
      det = a1 * m1 - b1 * m2 + c1 * m3;
      adet = det < 0 ? -det : det;
      if (det == 0 || adet < longint'(det_tol)) begin
        r.outcome = OUT_SINGULAR;
        return r;
      end
      nx = wide_t'(-(d1 * m1)) + wide_t'(b1 * (d2 * c3 - d3 * c2))
         - wide_t'(c1 * (d2 * b3 - d3 * b2));
      ny = -wide_t'(a1 * (d2 * c3 - d3 * c2)) + wide_t'(d1 * m2)
         - wide_t'(c1 * (a2 * d3 - a3 * d2));
      nz = -wide_t'(a1 * (b2 * d3 - b3 * d2)) + wide_t'(b1 * (a2 * d3 - a3 * d2))
         - wide_t'(d1 * m3);
      sat = 1'b0;
      r.px = divide_coord(nx, det, sat);
      r.py = divide_coord(ny, det, sat);
      r.pz = divide_coord(nz, det, sat);
      r.sat = sat;
      return r;
    endfunction

    function void note_planes(planes_t p);
      pending_q.push_back(predict_point(p));
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending_q.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (want.outcome <= OUT_SINGULAR) outcome_cnt[want.outcome]++;
      if (want.sat) sat_cnt++;
      if (got.px !== want.px) begin
        $error("point_x: expected %0d, got %0d", want.px, got.px);
        errors++;
      end
      if (got.py !== want.py) begin
        $error("point_y: expected %0d, got %0d", want.py, got.py);
        errors++;
      end
      if (got.pz !== want.pz) begin
        $error("point_z: expected %0d, got %0d", want.pz, got.pz);
        errors++;
      end
      if (got.outcome !== want.outcome) begin
        $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
        errors++;
      end
      if (got.sat !== want.sat) begin
        $error("saturated: expected %0d, got %0d", want.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_index_i = CFG_DET_TOL;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [COORD_W-1:0] point_x_o, point_y_o, point_z_o;
  logic [1:0]        outcome_o;
  logic              saturated_o;
  planes_t           cur;

  intersect_scoreboard sb = new();
  logic quiet = 1'b0;
  logic long_hold = 1'b0;
  int   cycles = 0;

  three_plane_intersect_cramer dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .first_normal_x_i(cur.nrm[0][0]), .first_normal_y_i(cur.nrm[0][1]),
    .first_normal_z_i(cur.nrm[0][2]), .first_offset_i(cur.ofs[0]),
    .second_normal_x_i(cur.nrm[1][0]), .second_normal_y_i(cur.nrm[1][1]),
    .second_normal_z_i(cur.nrm[1][2]), .second_offset_i(cur.ofs[1]),
    .third_normal_x_i(cur.nrm[2][0]), .third_normal_y_i(cur.nrm[2][1]),
    .third_normal_z_i(cur.nrm[2][2]), .third_offset_i(cur.ofs[2]),
    .out_valid_o, .out_ready_i,
    .point_x_o, .point_y_o, .point_z_o, .outcome_o, .saturated_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Monitors for accepted input and result words.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_planes(cur);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_point('{px: point_x_o, py: point_y_o, pz: point_z_o,
                       outcome: outcome_e'(outcome_o), sat: saturated_o});
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i = 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
        out_ready_i = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 12);
        out_ready_i = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  function automatic planes_t build(int v[12]);
    planes_t p;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) p.nrm[i][k] = NRM_W'(v[i * 4 + k]);
      p.ofs[i] = v[i * 4 + 3];
    end
    return p;
  endfunction

  // Random planes of several flavors: mostly solvable, some near-degenerate.
  function automatic planes_t random_planes();
    planes_t p;
    int flavor;
    flavor = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        case (flavor)
          0, 1, 2, 3: p.nrm[i][k] = NRM_W'($urandom);
          4, 5:       p.nrm[i][k] = NRM_W'((k == i) ? $urandom_range(8192, 32767)
                                   : $signed(16'($urandom_range(0, 8191))) - 4096);
          6:          p.nrm[i][k] = NRM_W'($signed(16'($urandom_range(0, 15))) - 8);
          default:    p.nrm[i][k] = (i == 0) ? NRM_W'($urandom)
                                   : NRM_W'(p.nrm[0][k] + $signed(16'($urandom_range(0, 7)))
                                            - 4);
        endcase
      end
      p.ofs[i] = ($urandom_range(0, 1) == 1) ? $urandom
                                             : $signed(32'($urandom_range(0, 2000000))) - 1000000;
    end
    if (flavor == 9) p.nrm[2] = p.nrm[1];
    return p;
  endfunction

  task automatic send(planes_t p);
    int n;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 12);
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    cur = p;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (sb.pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_DET_TOL) sb.det_tol = val[DTOL_W-1:0];
    else sb.par_tol = val[PTOL_W-1:0];
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send(random_planes());
  endtask

  // Hand-picked words: axis-aligned planes, range limits, degenerate normals.
  task automatic run_directed();
    send(build('{16384, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 16384, 0}));
    send(build('{16384, 0, 0, 32'h8000_0000, 0, 16384, 0, 32'h7FFF_FFFF,
                 0, 0, 16384, 65536}));
    send(build('{-16384, 0, 0, 32'h7FFF_FFFF, 0, -16384, 0, 32'h8000_0000,
                 0, 0, -16384, -1}));
    send(build('{-32768, -32768, -32768, 0, -32768, -32768, -32768, 0,
                 -32768, -32768, -32768, 0}));
    send(build('{32767, 0, 0, 32'h7FFF_FFFF, 0, 32767, 0, 32'h7FFF_FFFF,
                 0, 0, 32767, 32'h7FFF_FFFF}));
    send(build('{-32768, 0, 0, 32'h8000_0000, 0, -32768, 0, 32'h8000_0000,
                 0, 0, -32768, 32'h8000_0000}));
    send(build('{1, 0, 0, 5, 0, 1, 0, -5, 0, 0, 1, 1}));
    send(build('{1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0}));
    send(build('{16384, 16384, 0, 100, 16384, 16384, 0, 200, 0, 0, 16384, 0}));
    send(build('{16384, 0, 0, 1, 16384, 0, 0, 2, 16384, 0, 0, 3}));
    send(build('{16384, 1, 0, 1, 16384, 0, 1, 2, 16384, 0, 0, 3}));
    send(build('{-32768, 32767, 0, 123456, 0, -32768, 32767, -654321,
                 32767, 0, -32768, 7}));
    send(build('{0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 16384, 0}));
    send(build('{9000, -12000, 500, -400000, 3000, 15000, -7000, 250000,
                 -11000, 2000, 13000, 90000}));
    send(build('{2, 1, 0, 32'h7FFF_FFFF, 1, 2, 1, 32'h8000_0000, 0, 1, 2, 32'h7FFF_FFFF}));
  endtask

  initial begin
    foreach (cur.nrm[i, k]) cur.nrm[i][k] = '0;
    foreach (cur.ofs[i]) cur.ofs[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset tolerances first.
    run_random(250);
    drain();

    // Loosest determinant test, so any nonzero det passes; parallel limit at its smallest nonzero value.
    write_reg(CFG_DET_TOL, '0);
    write_reg(CFG_PAR_TOL, CFG_W'(1));
    run_directed();
    run_random(250);
    drain();

    // Both tolerances at their maximum.
    write_reg(CFG_DET_TOL, CFG_W'({DTOL_W{1'b1}}));
    write_reg(CFG_PAR_TOL, CFG_W'({PTOL_W{1'b1}}));
    run_random(150);
    drain();

    // Moderate tolerances; the receiver holds off long enough to fill the block.
    write_reg(CFG_DET_TOL, CFG_W'(47'd1 << 40));
    write_reg(CFG_PAR_TOL, CFG_W'(30'd1 << 26));
    run_random(100);
    long_hold = 1'b1;
    run_random(250);
    drain();

    // Final stretch with no idling on either side.
    write_reg(CFG_DET_TOL, '0);
    write_reg(CFG_PAR_TOL, '0);
    quiet = 1'b1;
    run_random(400);
    drain();

    $display("Checked %0d results: %0d points, %0d parallel, %0d singular, %0d clamped.",
             sb.checked, sb.outcome_cnt[OUT_FOUND], sb.outcome_cnt[OUT_PARALLEL],
             sb.outcome_cnt[OUT_SINGULAR], sb.sat_cnt);
    $display("Five tolerance settings were used, with random and long output stalls.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tpic_pkg.sv
hw/rtl/tpic_front.sv
hw/rtl/tpic_queue.sv
hw/rtl/tpic_div_stage.sv
hw/rtl/tpic_back.sv
hw/rtl/three_plane_intersect_cramer.sv
test/tb_three_plane_intersect_cramer.sv
